>>> rtl/core/ssaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_pkg
// Shared constants, types and tables for the block downscaler.
// ----------------------------------------------------------------------------
package ssaa_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 16;

  localparam int PIX_W       = 8;
  localparam int NUM_CH      = 3;
  localparam int SUM_W       = 16;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_W     = 13;

  localparam int FACTOR_W     = 5;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 13;
  localparam int GAUSS_FACTOR = 3;

  localparam logic [FACTOR_W-1:0]   RST_SCALE  = 5'd2;
  localparam logic                  RST_COLOUR = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 13'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 4'd0,
    REG_COLOUR = 4'd1,
    REG_WIDTH  = 4'd2,
    REG_HEIGHT = 4'd3
  } cfg_reg_t;

  // 1-2-1 / 2-4-2 / 1-2-1 weights as left shifts
  localparam logic [1:0] GAUSS_SHIFT [4][4] = '{
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0}
  };

  typedef struct packed {
    logic       active;
    logic       first;
    logic       emit;
    logic       frame_end;
    logic [1:0] shift;
  } pix_ctl_t;

  typedef struct packed {
    logic             vld;
    logic             fe;
    logic [PIX_W-1:0] q;
  } lane_res_t;

  typedef struct packed {
    logic                         fe;
    logic [NUM_CH-1:0][PIX_W-1:0] pix;
  } out_item_t;

  // ceil(2^24 / f^2); the gaussian factor divides by 16 instead
  function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] m;
    case (f)
      5'd1:    m = 25'd16777216;
      5'd2:    m = 25'd4194304;
      5'd3:    m = 25'd1048576;
      5'd4:    m = 25'd1048576;
      5'd5:    m = 25'd671089;
      5'd6:    m = 25'd466034;
      5'd7:    m = 25'd342393;
      5'd8:    m = 25'd262144;
      5'd9:    m = 25'd207127;
      5'd10:   m = 25'd167773;
      5'd11:   m = 25'd138655;
      5'd12:   m = 25'd116509;
      5'd13:   m = 25'd99274;
      5'd14:   m = 25'd85599;
      5'd15:   m = 25'd74566;
      5'd16:   m = 25'd65536;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/ssaa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_ctrl
// Configuration registers, raster position counters and per-pixel control.
// ----------------------------------------------------------------------------
module ssaa_ctrl #(
  parameter int MAX_WIDTH  = ssaa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = ssaa_pkg::DEF_MAX_FACTOR
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_valid,
  input  logic [ssaa_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [ssaa_pkg::CFG_DATA_W-1:0]                cfg_data,
  input  logic                                           take,
  input  logic [ssaa_pkg::NUM_CH-1:0][ssaa_pkg::PIX_W-1:0] px_in,
  output ssaa_pkg::pix_ctl_t                             ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]                   addr,
  output logic [ssaa_pkg::NUM_CH-1:0][ssaa_pkg::PIX_W-1:0] px_out,
  output logic [ssaa_pkg::RECIP_W-1:0]                   recip
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int BW = $clog2(MAX_FACTOR);
  localparam int XW = (WW > ssaa_pkg::HEIGHT_W) ? WW : ssaa_pkg::HEIGHT_W;
  localparam int HW = ssaa_pkg::HEIGHT_W;
  localparam int RW = ssaa_pkg::ROW_W;

  logic [ssaa_pkg::FACTOR_W-1:0]   sf_r;
  logic                            cm_r;
  logic [ssaa_pkg::CFG_DATA_W-1:0] iw_r;
  logic [ssaa_pkg::CFG_DATA_W-1:0] ih_r;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [BW-1:0] cib_r, cib_nxt;
  logic [BW-1:0] rib_r, rib_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;

  logic          restart;
  logic [FW-1:0] f_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          col_wrap, row_wrap, cib_wrap, rib_wrap;
  logic [WW:0]   col_end, col_next;
  logic [HW:0]   row_end, row_next;
  logic          col_fit, row_fit, last_cblk, last_rblk;

  always_comb begin
    case (ssaa_pkg::cfg_reg_t'(cfg_index))
      ssaa_pkg::REG_SCALE,
      ssaa_pkg::REG_COLOUR,
      ssaa_pkg::REG_WIDTH,
      ssaa_pkg::REG_HEIGHT: restart = cfg_valid;
      default:              restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= ssaa_pkg::RST_SCALE;
      cm_r <= ssaa_pkg::RST_COLOUR;
      iw_r <= ssaa_pkg::RST_WIDTH;
      ih_r <= ssaa_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      case (ssaa_pkg::cfg_reg_t'(cfg_index))
        ssaa_pkg::REG_SCALE:  sf_r <= cfg_data[ssaa_pkg::FACTOR_W-1:0];
        ssaa_pkg::REG_COLOUR: cm_r <= cfg_data[0];
        ssaa_pkg::REG_WIDTH:  iw_r <= cfg_data;
        ssaa_pkg::REG_HEIGHT: ih_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective factor, width and height after clamping
  always_comb begin
    if (sf_r == '0) begin
      f_eff = FW'(1);
    end else if (sf_r > ssaa_pkg::FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(sf_r);
    end
    if (iw_r == '0) begin
      w_eff = WW'(1);
    end else if (XW'(iw_r) > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw_r);
    end
    if (ih_r == '0) begin
      h_eff = HW'(1);
    end else if (ih_r > HW'(ssaa_pkg::HEIGHT_LIMIT)) begin
      h_eff = HW'(ssaa_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = ih_r;
    end
  end

  // whole-block checks without a divider: block start plus factor against size
  always_comb begin
    col_end   = (WW+1)'(in_col_r) - (WW+1)'(cib_r) + (WW+1)'(f_eff);
    col_next  = (WW+1)'(in_col_r) + (WW+1)'(f_eff) + (WW+1)'(1);
    row_end   = (HW+1)'(in_row_r) - (HW+1)'(rib_r) + (HW+1)'(f_eff);
    row_next  = (HW+1)'(in_row_r) + (HW+1)'(f_eff) + (HW+1)'(1);
    col_fit   = col_end <= (WW+1)'(w_eff);
    row_fit   = row_end <= (HW+1)'(h_eff);
    last_cblk = col_next > (WW+1)'(w_eff);
    last_rblk = row_next > (HW+1)'(h_eff);
  end

  always_comb begin
    col_wrap = WW'(in_col_r) >= w_eff - WW'(1);
    row_wrap = HW'(in_row_r) >= h_eff - HW'(1);
    cib_wrap = FW'(cib_r) >= f_eff - FW'(1);
    rib_wrap = FW'(rib_r) >= f_eff - FW'(1);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    out_col_nxt = out_col_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      cib_nxt     = '0;
      rib_nxt     = '0;
      out_col_nxt = '0;
    end else if (take) begin
      if (col_wrap) begin
        in_col_nxt  = '0;
        cib_nxt     = '0;
        out_col_nxt = '0;
        if (row_wrap) begin
          in_row_nxt = '0;
          rib_nxt    = '0;
        end else begin
          in_row_nxt = in_row_r + RW'(1);
          rib_nxt    = rib_wrap ? '0 : rib_r + BW'(1);
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
        if (cib_wrap) begin
          cib_nxt     = '0;
          out_col_nxt = out_col_r + CW'(1);
        end else begin
          cib_nxt = cib_r + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      out_col_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  always_comb begin
    ctl.active    = col_fit && row_fit;
    ctl.first     = (cib_r == '0) && (rib_r == '0);
    ctl.emit      = col_fit && row_fit && (FW'(cib_r) == f_eff - FW'(1)) &&
                    (FW'(rib_r) == f_eff - FW'(1));
    ctl.frame_end = last_cblk && last_rblk;
    if (f_eff == FW'(ssaa_pkg::GAUSS_FACTOR)) begin
      ctl.shift = ssaa_pkg::GAUSS_SHIFT[2'(rib_r)][2'(cib_r)];
    end else begin
      ctl.shift = 2'd0;
    end
  end

  assign addr      = out_col_r;
  assign px_out[0] = px_in[0];
  assign px_out[1] = cm_r ? px_in[1] : '0;
  assign px_out[2] = cm_r ? px_in[2] : '0;
  assign recip     = ssaa_pkg::recip_of(ssaa_pkg::FACTOR_W'(f_eff));

endmodule

>>> rtl/core/ssaa_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_lane
// One colour channel: column sum memory with read-modify-write, then divide
// by the block area through a reciprocal multiply.
// ----------------------------------------------------------------------------
module ssaa_lane #(
  parameter int MAX_WIDTH = ssaa_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          take,
  input  ssaa_pkg::pix_ctl_t            ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
  input  logic [ssaa_pkg::PIX_W-1:0]    px,
  input  logic [ssaa_pkg::RECIP_W-1:0]  recip,
  output ssaa_pkg::lane_res_t           res
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [ssaa_pkg::SUM_W-1:0] mem [MAX_WIDTH];
  logic [ssaa_pkg::SUM_W-1:0] rd_r;

  logic                       a_vld_r;
  ssaa_pkg::pix_ctl_t         a_ctl_r;
  logic [CW-1:0]              a_addr_r;
  logic [ssaa_pkg::PIX_W-1:0] a_px_r;

  logic                       fw_vld_r;
  logic [CW-1:0]              fw_addr_r;
  logic [ssaa_pkg::SUM_W-1:0] fw_data_r;

  logic                       b_vld_r, b_fe_r;
  logic [ssaa_pkg::SUM_W-1:0] b_sum_r;
  logic                       c_vld_r, c_fe_r;
  logic [ssaa_pkg::PROD_W-1:0] c_prod_r;

  logic [ssaa_pkg::SUM_W-1:0] wgt, old_sum, new_sum;
  logic                       wr_en;

  // the write of the previous item lands on the same edge as this read
  always_comb begin
    wgt     = ssaa_pkg::SUM_W'(a_px_r) << a_ctl_r.shift;
    old_sum = (fw_vld_r && (fw_addr_r == a_addr_r)) ? fw_data_r : rd_r;
    new_sum = (a_ctl_r.first ? '0 : old_sum) + wgt;
    wr_en   = a_vld_r && a_ctl_r.active;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem[a_addr_r] <= new_sum;
      end
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      fw_vld_r <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
    end else if (adv) begin
      a_vld_r  <= take;
      fw_vld_r <= wr_en;
      b_vld_r  <= wr_en && a_ctl_r.emit;
      c_vld_r  <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl_r   <= ctl;
      a_addr_r  <= addr;
      a_px_r    <= px;
      fw_addr_r <= a_addr_r;
      fw_data_r <= new_sum;
      b_fe_r    <= a_ctl_r.frame_end;
      b_sum_r   <= new_sum;
      c_fe_r    <= b_fe_r;
      c_prod_r  <= b_sum_r * recip;
    end
  end

  assign res.vld = c_vld_r;
  assign res.fe  = c_fe_r;
  assign res.q   = c_prod_r[ssaa_pkg::RECIP_SHIFT +: ssaa_pkg::PIX_W];

endmodule

>>> rtl/core/ssaa_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_merge
// Joins the lane results into one output pixel and holds up to two of them
// in a small output buffer that decouples the pipeline from the sink.
// ----------------------------------------------------------------------------
module ssaa_merge (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  ssaa_pkg::lane_res_t [ssaa_pkg::NUM_CH-1:0]        res,
  output logic                                              adv,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [ssaa_pkg::NUM_CH*ssaa_pkg::PIX_W-1:0]       out_tdata,
  output logic                                              out_tlast
);

  localparam int BUF_DEPTH = 2;

  ssaa_pkg::out_item_t ent0_r, ent0_nxt;
  ssaa_pkg::out_item_t ent1_r, ent1_nxt;
  ssaa_pkg::out_item_t new_item;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pop;

  always_comb begin
    new_item.fe = res[0].fe;
    for (int ch = 0; ch < ssaa_pkg::NUM_CH; ch++) begin
      new_item.pix[ch] = res[ch].q;
    end
  end

  assign adv  = cnt_r != 2'(BUF_DEPTH);
  assign push = adv && res[0].vld;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          ent0_nxt = new_item;
        end else begin
          ent1_nxt = new_item;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        // push implies room and pop an entry, so the buffer holds only the head
        if (cnt_r == 2'd1) begin
          ent0_nxt = new_item;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = new_item;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = ent0_r.pix;
  assign out_tlast  = ent0_r.fe;

endmodule

>>> rtl/core/ssaa_block_downscaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_block_downscaler
// Block downscaler: box mean per factor-by-factor block, 3x3 gaussian at
// factor 3, with three colour lanes and a merged output stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one per clock and are accepted in every
// cycle the output buffer has room; a block's result passes lane stages a, b
// and c, then the output buffer. Each colour lane owns a column sum memory of
// MAX_WIDTH entries with one read and one write port: the sum for a pixel is
// read on the accept edge and written back on the next advance, with the
// write forwarded to an immediately following pixel of the same block
// column, which is what holds the rate at one pixel per cycle. The divide by
// the block area is a multiply by a reciprocal in its own stage. A two-entry
// output buffer takes results while the sink stalls; input ready drops only
// when it is full. Configuration writes are taken in any cycle, restart the
// frame when they address one of the four registers, and are meant to be
// issued only when no pixel is in flight. Memory contents need no clearing
// after reset since each block overwrites its column sum on its first pixel.
module ssaa_block_downscaler #(
  parameter int MAX_WIDTH  = ssaa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = ssaa_pkg::DEF_MAX_FACTOR
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [ssaa_pkg::NUM_CH*ssaa_pkg::PIX_W-1:0] in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic [ssaa_pkg::NUM_CH*ssaa_pkg::PIX_W-1:0] out_tdata,
  output logic                                        out_tlast,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [ssaa_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [ssaa_pkg::CFG_DATA_W-1:0]             cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                                              adv, take;
  ssaa_pkg::pix_ctl_t                                ctl;
  logic [CW-1:0]                                     addr;
  logic [ssaa_pkg::NUM_CH-1:0][ssaa_pkg::PIX_W-1:0]  px_in, px;
  logic [ssaa_pkg::RECIP_W-1:0]                      recip;
  ssaa_pkg::lane_res_t [ssaa_pkg::NUM_CH-1:0]        res;

  assign in_tready = adv;
  assign take      = in_tvalid && adv;
  assign cfg_ready = 1'b1;
  assign px_in     = in_tdata;

  ssaa_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .px_in     (px_in),
    .ctl       (ctl),
    .addr      (addr),
    .px_out    (px),
    .recip     (recip)
  );

  for (genvar ch = 0; ch < ssaa_pkg::NUM_CH; ch++) begin : g_lane
    ssaa_lane #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .take  (take),
      .ctl   (ctl),
      .addr  (addr),
      .px    (px[ch]),
      .recip (recip),
      .res   (res[ch])
    );
  end

  ssaa_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/ssaa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_chk
// Port-level checks on the block downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module ssaa_chk (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_tready,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [ssaa_pkg::NUM_CH*ssaa_pkg::PIX_W-1:0] out_tdata,
  input logic                                        out_tlast,
  input logic                                        cfg_valid,
  input logic                                        cfg_ready,
  input logic [ssaa_pkg::CFG_IDX_W-1:0]              cfg_index,
  input logic [ssaa_pkg::CFG_DATA_W-1:0]             cfg_data
);

  logic grey_r;

  // track the colour mode as written through the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grey_r <= !ssaa_pkg::RST_COLOUR;
    end else if (cfg_valid && cfg_ready && (cfg_index == ssaa_pkg::REG_COLOUR)) begin
      grey_r <= !cfg_data[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // input is held off only with a full buffer, which no transfer drained
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tvalid && out_tready))
    else $error("input stalled without a full output buffer");

  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && grey_r |-> out_tdata[ssaa_pkg::NUM_CH*ssaa_pkg::PIX_W-1:ssaa_pkg::PIX_W] == '0)
    else $error("green or blue nonzero in grey mode");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind ssaa_block_downscaler ssaa_chk u_ssaa_chk (.*);
